// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge and held off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names of the project.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/tsps_pkg.sv -----
// Package with the constants and types of the transport stream sync filter.
`timescale 1ns / 1ps

package tsps_pkg;

  // Packet geometry.
  localparam int unsigned PktLen = 188;
  localparam int unsigned WinLen = 2 * PktLen;
  localparam int unsigned FillW  = $clog2(WinLen + 1);
  localparam int unsigned LeftW  = 8;

  // Stream byte values.
  localparam logic [7:0]  SyncByte = 8'h47;
  localparam logic [12:0] NullPid  = 13'h1FFF;
  localparam logic [4:0]  PidHiMask = 5'h1F;

  // One result byte with its packet marks.
  typedef struct packed {
    logic       last;
    logic       first;
    logic [7:0] data;
  } tsps_out_t;

endpackage

// ----- design/tsps_cell.sv -----
// One byte stage of the packet window shift chain.
`timescale 1ns / 1ps

module tsps_cell import tsps_pkg::*; (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  // The stage takes its neighbor's byte whenever the chain advances.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ----- design/tsps_skid.sv -----
// Two-entry output buffer that decouples the window from the output stall.
`timescale 1ns / 1ps

module tsps_skid import tsps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tsps_out_t push_data_i,
  output logic      space_o,
  output logic      valid_o,
  output tsps_out_t data_o,
  input  logic      ready_i
);

  logic      main_valid_q;
  logic      skid_valid_q;
  tsps_out_t main_q;
  tsps_out_t skid_q;
  logic      pop;

  assign pop = main_valid_q && ready_i;

  // Valid flags of both entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q) begin
      main_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload of both entries; the skid entry refills the main one first.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (!main_valid_q) begin
      main_q <= push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign space_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

// ----- design/ts_packet_sync_null_filter.sv -----
// Top level: transport stream packet sync and null packet filter.
//
//   Channel  Dir  tdata (low bit up)  tuser      tlast
//   s_axis   in   in_byte[7:0]        -          -
//   m_axis   out  out_byte[7:0]       pkt_first  pkt_last
//
// One byte is taken per clock while s_axis_tready_o is high; each byte moves the
// 376-stage shift chain by one stage and pushes any result into the output buffer.
// The first 376 bytes after reset only fill the chain and give no result.
// Reset clears the fill count and the packet state; window bytes need none.
// A stalled output fills the two-entry output buffer; s_axis_tready_o drops
// only while its second entry is occupied.
`timescale 1ns / 1ps

module ts_packet_sync_null_filter import tsps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] pkt_first
  output logic       m_axis_tlast_o    // pkt_last
);

  logic [7:0]       win_tap [WinLen];
  logic             accept;
  logic             full;
  logic [FillW-1:0] fill_q, fill_d;
  logic             in_pkt_q, in_pkt_d;
  logic             drop_q, drop_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [7:0]       oldest;
  logic             sync_ok;
  logic             is_null;
  logic             emit;
  logic             first;
  logic             last;
  tsps_out_t        res;
  tsps_out_t        out_data;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Shift chain holding two packets; the last stage holds the oldest byte.
  for (genvar k = 0; k < WinLen; k++) begin : g_win
    if (k == 0) begin : g_head
      tsps_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .data_i  (s_axis_tdata_i),
        .data_o  (win_tap[k])
      );
    end else begin : g_body
      tsps_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (accept),
        .data_i  (win_tap[k-1]),
        .data_o  (win_tap[k])
      );
    end
  end

  // Sync test on the oldest byte and the one a packet later, PID check.
  assign full    = (fill_q == FillW'(WinLen));
  assign oldest  = win_tap[WinLen-1];
  assign sync_ok = (oldest == SyncByte) && (win_tap[WinLen-1-PktLen] == SyncByte);
  assign is_null = ({win_tap[WinLen-2][4:0] & PidHiMask, win_tap[WinLen-3]} == NullPid);

  // Packet state: fill, hunt, lock and count down.
  always_comb begin
    fill_d   = fill_q;
    in_pkt_d = in_pkt_q;
    drop_d   = drop_q;
    left_d   = left_q;
    emit     = 1'b0;
    first    = 1'b0;
    last     = 1'b0;
    if (accept) begin
      if (!full) begin
        fill_d = fill_q + FillW'(1);
      end else if (in_pkt_q) begin
        emit   = !drop_q;
        left_d = left_q - LeftW'(1);
        if (left_d == '0) begin
          last     = 1'b1;
          in_pkt_d = 1'b0;
        end
      end else if (sync_ok) begin
        drop_d   = is_null;
        in_pkt_d = 1'b1;
        left_d   = LeftW'(PktLen - 1);
        first    = 1'b1;
        emit     = !is_null;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      in_pkt_q <= 1'b0;
      drop_q   <= 1'b0;
      left_q   <= '0;
    end else begin
      fill_q   <= fill_d;
      in_pkt_q <= in_pkt_d;
      drop_q   <= drop_d;
      left_q   <= left_d;
    end
  end

  // Result transaction into the output buffer.
  assign res.data  = oldest;
  assign res.first = first;
  assign res.last  = last;

  tsps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (res),
    .space_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .data_o      (out_data),
    .ready_i     (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_data.data;
  assign m_axis_tuser_o = out_data.first;
  assign m_axis_tlast_o = out_data.last;

endmodule

// ----- design/tsps_checker.sv -----
// Port-level checker for the transport stream sync filter, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsps_checker import tsps_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  logic out_xfer;
  logic open_q;

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Tracks whether a kept packet has started but not yet ended on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (out_xfer) begin
      open_q <= !m_axis_tlast_o;
    end
  end

  `ASSERT_STD(a_first_not_last, out_xfer |-> !(m_axis_tuser_o && m_axis_tlast_o), "first and last marks on one transaction")
  `ASSERT_STD(a_first_when_closed, (out_xfer && m_axis_tuser_o) |-> !open_q, "packet start inside an open packet")
  `ASSERT_STD(a_body_when_open, (out_xfer && !m_axis_tuser_o) |-> open_q, "packet byte outside a packet")
  `ASSERT_STD(a_stall_only_when_full, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled with empty output")
  `ASSERT_STD(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled output transaction changed")

endmodule

bind ts_packet_sync_null_filter tsps_checker u_tsps_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the transport stream packet sync and null filter.
`timescale 1ns / 1ps

module tb;
  import tsps_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainHold  = 16;
  localparam int unsigned RandBytes  = 200;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  // Shadow copy of the sync filter state.
  logic [7:0]  ts_window [WinLen];
  int unsigned win_fill = 0;
  int unsigned win_oldest = 0;
  bit          locked = 1'b0;
  bit          null_pkt = 1'b0;
  logic [7:0]  pkt_left = '0;

  // Bytes of kept packets that are still to come out, oldest first.
  tsps_out_t   pending_out [$];

  bit          idle_on = 1'b0;
  int unsigned out_stall = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned kept_pkts = 0;
  int unsigned null_pkts = 0;
  int unsigned pauses = 0;
  int unsigned quiet_cycles = 0;

  ts_packet_sync_null_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),    // [7:0] in_byte
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),    // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser),    // [0] pkt_first
    .m_axis_tlast_o  (m_axis_tlast)     // pkt_last
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the shadow state by one accepted byte and queue any kept byte.
  task automatic track_stream_byte(input logic [7:0] in_b);
    logic [7:0]  oldest;
    logic [12:0] pid;
    tsps_out_t   res;
    bit          emit;
    emit = 1'b0;
    res  = '0;
    if (win_fill < WinLen) begin
      ts_window[(win_oldest + win_fill) % WinLen] = in_b;
      win_fill++;
    end else begin
      oldest = ts_window[win_oldest];
      if (locked) begin
        emit = !null_pkt;
        pkt_left = pkt_left - 8'd1;
        if (pkt_left == 8'd0) begin
          res.last = 1'b1;
          locked = 1'b0;
        end
      end else if (oldest == SyncByte &&
                   ts_window[(win_oldest + PktLen) % WinLen] == SyncByte) begin
        pid = {ts_window[(win_oldest + 1) % WinLen][4:0] & PidHiMask,
               ts_window[(win_oldest + 2) % WinLen]};
        null_pkt = (pid == NullPid);
        locked = 1'b1;
        pkt_left = 8'(PktLen - 1);
        res.first = 1'b1;
        emit = !null_pkt;
        if (null_pkt) null_pkts++;
        else kept_pkts++;
      end
      // The new byte takes the slot of the one that just left.
      res.data = oldest;
      ts_window[win_oldest] = in_b;
      win_oldest = (win_oldest + 1) % WinLen;
      if (emit) pending_out.insert(pending_out.size(), res);
    end
  endtask

  // Drive one byte from a falling edge and return at the falling edge after
  // its transaction; tvalid is left high for a back-to-back byte.
  task automatic send_stream_byte(input logic [7:0] in_b);
    int unsigned gap;
    bit          taken;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= in_b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready;
    end
    track_stream_byte(in_b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Lower tvalid at the falling edge where a byte would otherwise start.
  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // One packet: sync byte, PID with random flag bits, then the payload.
  task automatic send_ts_packet(input logic [7:0] sync_b, input logic [12:0] pid,
                                input int unsigned len, input bit rand_pay,
                                input logic [7:0] pay_val);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0: begin
          b = sync_b;
        end
        1: begin
          b = {3'($urandom_range(0, 7)), pid[12:8]};
        end
        2: begin
          b = pid[7:0];
        end
        default: begin
          b = rand_pay ? 8'($urandom_range(0, 255)) : pay_val;
        end
      endcase
      send_stream_byte(b);
    end
  endtask

  // Hold the sender until every kept byte queued so far has come out.
  task automatic pause_until_drained();
    stop_sending();
    while (pending_out.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    pauses++;
  endtask

  // Bytes that arrive while the window is still filling, lone syncs among them.
  task automatic test_fill_window();
    idle_on = 1'b0;
    send_stream_byte(SyncByte);
    send_stream_byte(8'h00);
    send_stream_byte(8'hFF);
    send_stream_byte(SyncByte);
    send_stream_byte(8'h00);
  endtask

  // Kept, null and broken packets back to back, with payload extremes.
  task automatic test_packet_kinds();
    send_ts_packet(SyncByte, 13'h0000, PktLen, 1'b0, 8'h00);
    send_ts_packet(SyncByte, NullPid, PktLen, 1'b0, 8'hFF);
    idle_on = 1'b1;
    send_ts_packet(SyncByte, 13'h1FFE, PktLen, 1'b0, 8'hFF);
    send_ts_packet(8'h46, 13'h0100, PktLen, 1'b0, 8'h00);
  endtask

  // Sender stops in mid packet until the output is empty, then resumes.
  task automatic test_sender_pause();
    send_ts_packet(SyncByte, 13'h0ABC, 100, 1'b1, 8'h00);
    pause_until_drained();
    for (int unsigned i = 100; i < PktLen; i++) send_stream_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets, mixed with broken syncs, cut packets and noise.
  task automatic test_random_stream();
    int unsigned start_cnt;
    int unsigned pick;
    logic [12:0] pid;
    logic [7:0]  bad_sync;
    start_cnt = bytes_sent;
    while (bytes_sent < start_cnt + RandBytes) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      pid = ($urandom_range(0, 3) == 0) ? NullPid : 13'($urandom_range(0, 8191));
      if (pick < 60) begin
        send_ts_packet(SyncByte, pid, PktLen, 1'b1, 8'h00);
      end else if (pick < 70) begin
        bad_sync = 8'($urandom_range(0, 255));
        if (bad_sync == SyncByte) bad_sync = bad_sync ^ 8'h01;
        send_ts_packet(bad_sync, pid, PktLen, 1'b1, 8'h00);
      end else if (pick < 82) begin
        send_ts_packet(SyncByte, pid, $urandom_range(1, PktLen - 1), 1'b1, 8'h00);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 30)) begin
          if ($urandom_range(0, 3) == 0) send_stream_byte(SyncByte);
          else send_stream_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        pause_until_drained();
      end
    end
  endtask

  // Receiver stall: after every result a new random wait is drawn, or none while idle_on is clear.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= (out_stall == 0);
      if (out_stall > 0) out_stall--;
    end
  end

  // Compare each output transaction with the oldest queued byte.
  always @(posedge clk_i) begin
    tsps_out_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data=%h first=%b last=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        exp_b = pending_out[0];
        pending_out.delete(0);
        if (m_axis_tdata !== exp_b.data || m_axis_tuser !== exp_b.first ||
            m_axis_tlast !== exp_b.last) begin
          $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b (data/first/last)",
                   $time, exp_b.data, exp_b.first, exp_b.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end
        bytes_checked++;
      end
      out_stall = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Watchdog on cycles in which neither side moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_fill_window();
    test_packet_kinds();
    test_sender_pause();
    test_random_stream();
    stop_sending();
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DrainHold) @(posedge clk_i);
    $display("Sent %0d stream bytes with %0d sender pauses; checked %0d output bytes.",
             bytes_sent, pauses, bytes_checked);
    $display("Locked onto %0d kept packets and %0d null packets.", kept_pkts, null_pkts);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
